[rtl/mcsi_pkg.sv]
// Shared types, constants and tables of the Monte Carlo sine integrator.
// Used by mcsi_ctrl, mcsi_dp and monte_carlo_sine_integrator_unit; depends on nothing.
`default_nettype none

package mcsi_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Width of the CORDIC angle and vector registers (Q2.30 plus headroom).
    localparam int CW = 35;

    localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    localparam logic [32:0] GAIN_Q30    = 33'd652032874;

    localparam logic [1:0] KIND_EST   = 2'd0;
    localparam logic [1:0] KIND_MEAN  = 2'd1;
    localparam logic [1:0] KIND_SIGMA = 2'd2;

    localparam logic [2:0] REG_LOW    = 3'd0;
    localparam logic [2:0] REG_HIGH   = 3'd1;
    localparam logic [2:0] REG_BOTTOM = 3'd2;
    localparam logic [2:0] REG_TOP    = 3'd3;
    localparam logic [2:0] REG_POINTS = 3'd4;
    localparam logic [2:0] REG_RUNS   = 3'd5;

    localparam logic [1:0] DSRC_EST  = 2'd0;
    localparam logic [1:0] DSRC_MEAN = 2'd1;
    localparam logic [1:0] DSRC_MSQ  = 2'd2;

    localparam logic SQ_EST  = 1'b0;
    localparam logic SQ_MEAN = 1'b1;

    typedef struct packed {
        logic       load_point;
        logic       red_step;
        logic       fold;
        logic       cord_step;
        logic       hit;
        logic       mul_wh;
        logic       mul_lo;
        logic       mul_hi;
        logic       div_load;
        logic [1:0] div_src;
        logic       div_step;
        logic       take_est;
        logic       take_mean;
        logic       take_msq;
        logic       sq_step;
        logic       sq_src;
        logic       acc;
        logic       diff;
        logic       sqrt_step;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_final;
        logic       clear_burst;
        logic [6:0] idx;
    } mcsi_cmd_t;

    typedef struct packed {
        logic run_end;
        logic stats_due;
        logic out_free;
    } mcsi_sts_t;

    function automatic logic [CW-1:0] atan_q30(input logic [4:0] i);
        logic [CW-1:0] v;
        unique case (i)
            5'd0:    v = CW'(843314856);
            5'd1:    v = CW'(497837829);
            5'd2:    v = CW'(263043836);
            5'd3:    v = CW'(133525158);
            5'd4:    v = CW'(67021686);
            5'd5:    v = CW'(33543515);
            5'd6:    v = CW'(16775850);
            5'd7:    v = CW'(8388437);
            5'd8:    v = CW'(4194282);
            5'd9:    v = CW'(2097149);
            5'd10:   v = CW'(1048575);
            5'd11:   v = CW'(524287);
            5'd12:   v = CW'(262143);
            5'd13:   v = CW'(131071);
            5'd14:   v = CW'(65535);
            5'd15:   v = CW'(32767);
            5'd16:   v = CW'(16383);
            5'd17:   v = CW'(8191);
            5'd18:   v = CW'(4095);
            5'd19:   v = CW'(2047);
            5'd20:   v = CW'(1023);
            5'd21:   v = CW'(511);
            5'd22:   v = CW'(255);
            5'd23:   v = CW'(127);
            5'd24:   v = CW'(63);
            5'd25:   v = CW'(31);
            5'd26:   v = CW'(15);
            5'd27:   v = CW'(7);
            5'd28:   v = CW'(3);
            5'd29:   v = CW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/monte_carlo_sine_integrator_unit.sv]
// Top level of the hit-or-miss Monte Carlo sine integrator.
// Joins mcsi_ctrl and mcsi_dp; depends on mcsi_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, x_point, y_point      | in
//  result  | out_valid, out_ready, result_kind,        | out
//          | result_value, final_flag                  |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// A point runs through angle reduction, one quotient bit per cycle, then the
// CORDIC rotation, one step per cycle. A point that ends a run adds a pass
// through the 128-step shared divider; a burst end adds two more divides and a
// 48-step square root.
// Reset is asynchronous and clears all control state and counters.
// A waiting result stalls the sequencer whenever a new result must be loaded.
`default_nettype none

module monte_carlo_sine_integrator_unit #(
    parameter int CORDIC_STEPS  = mcsi_pkg::CORDIC_STEPS_DEF,
    parameter int FRACTION_BITS = mcsi_pkg::FRACTION_BITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire signed [31:0]  x_point,
    input  wire signed [31:0]  y_point,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [1:0]         result_kind,
    output logic signed [63:0] result_value,
    output logic               final_flag,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire [2:0]          cfg_index,
    input  wire [31:0]         cfg_data
);

    mcsi_pkg::mcsi_cmd_t cmd;
    mcsi_pkg::mcsi_sts_t sts;

    assign cfg_ready = 1'b1;

    mcsi_ctrl #(
        .CORDIC_STEPS  (CORDIC_STEPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mcsi_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .x_point      (x_point),
        .y_point      (y_point),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .result_value (result_value),
        .final_flag   (final_flag)
    );

    // A result is only loaded when the output register is free.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over an untaken result");

    // While a new request may enter, no iterative unit is running.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.cord_step || cmd.div_step || cmd.sqrt_step))
        else $error("iteration running while idle");

    // A point that ends no run frees the input on the next cycle.
    a_quiet_point: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.hit && !sts.run_end) |=> in_ready)
        else $error("quiet point did not return to idle");

    // Sigma always closes a burst.
    a_sigma_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == mcsi_pkg::KIND_SIGMA)) |-> final_flag)
        else $error("sigma without final flag");

endmodule

`default_nettype wire

[rtl/mcsi_ctrl.sv]
// Sequencer of the Monte Carlo sine integrator: one state machine with an
// iteration counter that drives the datapath. Depends on mcsi_pkg.
`default_nettype none

module mcsi_ctrl #(
    parameter int CORDIC_STEPS  = mcsi_pkg::CORDIC_STEPS_DEF,
    parameter int FRACTION_BITS = mcsi_pkg::FRACTION_BITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  mcsi_pkg::mcsi_sts_t sts,
    output mcsi_pkg::mcsi_cmd_t cmd
);

    localparam logic [6:0] RED_LAST  = 7'(28 - FRACTION_BITS);
    localparam logic [6:0] CORD_LAST = 7'(CORDIC_STEPS - 1);
    localparam logic [6:0] DIV_LAST  = 7'd127;
    localparam logic [6:0] SQ_LAST   = 7'd3;
    localparam logic [6:0] SQRT_LAST = 7'd47;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_RED    = 5'd1;
    localparam logic [4:0] ST_FOLD   = 5'd2;
    localparam logic [4:0] ST_CORD   = 5'd3;
    localparam logic [4:0] ST_HIT    = 5'd4;
    localparam logic [4:0] ST_MUL1   = 5'd5;
    localparam logic [4:0] ST_MUL2   = 5'd6;
    localparam logic [4:0] ST_MUL3   = 5'd7;
    localparam logic [4:0] ST_LDE    = 5'd8;
    localparam logic [4:0] ST_DIVE   = 5'd9;
    localparam logic [4:0] ST_TAKE_E = 5'd10;
    localparam logic [4:0] ST_SQE    = 5'd11;
    localparam logic [4:0] ST_ACC    = 5'd12;
    localparam logic [4:0] ST_EMIT_E = 5'd13;
    localparam logic [4:0] ST_DIVM   = 5'd14;
    localparam logic [4:0] ST_TAKE_M = 5'd15;
    localparam logic [4:0] ST_DIVQ   = 5'd16;
    localparam logic [4:0] ST_TAKE_Q = 5'd17;
    localparam logic [4:0] ST_SQM    = 5'd18;
    localparam logic [4:0] ST_DIFF   = 5'd19;
    localparam logic [4:0] ST_SQRT   = 5'd20;
    localparam logic [4:0] ST_EMIT_M = 5'd21;
    localparam logic [4:0] ST_EMIT_S = 5'd22;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [6:0] cnt_reg;
    logic [6:0] cnt_next;

    always_comb
    begin
        cmd        = '0;
        cmd.idx    = cnt_reg;
        in_ready   = 1'b0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_point = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_RED;
                end
            end
            ST_RED:
            begin
                cmd.red_step = 1'b1;
                if (cnt_reg == RED_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FOLD;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                cnt_next   = '0;
                state_next = ST_CORD;
            end
            ST_CORD:
            begin
                cmd.cord_step = 1'b1;
                if (cnt_reg == CORD_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_HIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_HIT:
            begin
                cmd.hit    = 1'b1;
                state_next = sts.run_end ? ST_MUL1 : ST_IDLE;
            end
            ST_MUL1:
            begin
                cmd.mul_wh = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_LDE;
            end
            ST_LDE:
            begin
                cmd.div_load = 1'b1;
                cmd.div_src  = mcsi_pkg::DSRC_EST;
                cnt_next     = '0;
                state_next   = ST_DIVE;
            end
            ST_DIVE, ST_DIVM, ST_DIVQ:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next = '0;
                    if (state_reg == ST_DIVE)
                    begin
                        state_next = ST_TAKE_E;
                    end
                    else if (state_reg == ST_DIVM)
                    begin
                        state_next = ST_TAKE_M;
                    end
                    else
                    begin
                        state_next = ST_TAKE_Q;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_TAKE_E:
            begin
                cmd.take_est = 1'b1;
                cnt_next     = '0;
                state_next   = ST_SQE;
            end
            ST_SQE, ST_SQM:
            begin
                cmd.sq_step = 1'b1;
                cmd.sq_src  = (state_reg == ST_SQM) ? mcsi_pkg::SQ_MEAN : mcsi_pkg::SQ_EST;
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == ST_SQM) ? ST_DIFF : ST_ACC;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_EMIT_E;
            end
            ST_EMIT_E:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = mcsi_pkg::KIND_EST;
                    cmd.emit_final = !sts.stats_due;
                    if (sts.stats_due)
                    begin
                        cmd.div_load = 1'b1;
                        cmd.div_src  = mcsi_pkg::DSRC_MEAN;
                        cnt_next     = '0;
                        state_next   = ST_DIVM;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAKE_M:
            begin
                cmd.take_mean = 1'b1;
                cmd.div_load  = 1'b1;
                cmd.div_src   = mcsi_pkg::DSRC_MSQ;
                cnt_next      = '0;
                state_next    = ST_DIVQ;
            end
            ST_TAKE_Q:
            begin
                cmd.take_msq = 1'b1;
                cnt_next     = '0;
                state_next   = ST_SQM;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT_M;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_EMIT_M:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = mcsi_pkg::KIND_MEAN;
                    state_next    = ST_EMIT_S;
                end
            end
            ST_EMIT_S:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = mcsi_pkg::KIND_SIGMA;
                    cmd.emit_final  = 1'b1;
                    cmd.clear_burst = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/mcsi_dp.sv]
// Datapath of the Monte Carlo sine integrator: configuration registers, angle
// reduction, CORDIC, hit counter, multipliers, shared divider, squarer, burst
// statistics, square root and the output register. Depends on mcsi_pkg.
`default_nettype none

module mcsi_dp #(
    parameter int FRACTION_BITS = mcsi_pkg::FRACTION_BITS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  mcsi_pkg::mcsi_cmd_t cmd,
    output mcsi_pkg::mcsi_sts_t sts,
    input  wire signed [31:0]   x_point,
    input  wire signed [31:0]   y_point,
    input  wire                 cfg_valid,
    input  wire [2:0]           cfg_index,
    input  wire [31:0]          cfg_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [1:0]          result_kind,
    output logic signed [63:0]  result_value,
    output logic                final_flag
);

    localparam int FB        = FRACTION_BITS;
    localparam int YSH       = 30 - FB;
    localparam int RW        = 62 - FB;
    localparam int RED_STEPS = 29 - FB;
    localparam int SSH       = (2 * FB < 32) ? 32 - 2 * FB : 0;
    localparam int DSH       = (2 * FB > 32) ? 2 * FB - 32 : 0;
    localparam int DIVW      = 24 + DSH;
    localparam int CW        = mcsi_pkg::CW;

    localparam logic [RW-1:0]        TWO_PI_R = RW'(mcsi_pkg::TWO_PI_Q30);
    localparam logic signed [CW-1:0] TWO_PI_S = CW'(mcsi_pkg::TWO_PI_Q30);
    localparam logic signed [CW-1:0] PI_S     = CW'(mcsi_pkg::PI_Q30);
    localparam logic signed [CW-1:0] HALF_S   = CW'(mcsi_pkg::HALF_PI_Q30);
    localparam logic signed [CW-1:0] GAIN_S   = CW'(mcsi_pkg::GAIN_Q30);
    localparam logic signed [63:0]   SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]   SMIN     = 64'h8000_0000_0000_0000;
    localparam logic signed [24:0]   BAL_MAX  = 25'h0FF_FFFF;
    localparam logic signed [24:0]   BAL_MIN  = 25'h100_0000;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? SMIN : SMAX;
        end
        return s[63:0];
    endfunction

    // Configuration registers.
    logic signed [31:0] low_reg;
    logic signed [31:0] high_reg;
    logic signed [31:0] bottom_reg;
    logic signed [31:0] top_reg;
    logic [23:0]        npts_reg;
    logic [15:0]        nruns_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg    <= 32'sd0;
            high_reg   <= 32'sd205887;
            bottom_reg <= -32'sd65536;
            top_reg    <= 32'sd65536;
            npts_reg   <= 24'd1000;
            nruns_reg  <= 16'd10;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mcsi_pkg::REG_LOW:    low_reg    <= cfg_data;
                mcsi_pkg::REG_HIGH:   high_reg   <= cfg_data;
                mcsi_pkg::REG_BOTTOM: bottom_reg <= cfg_data;
                mcsi_pkg::REG_TOP:    top_reg    <= cfg_data;
                mcsi_pkg::REG_POINTS: npts_reg   <= cfg_data[23:0];
                mcsi_pkg::REG_RUNS:   nruns_reg  <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    logic [23:0] n_eff;
    logic [15:0] k_eff;
    assign n_eff = (npts_reg == '0) ? 24'd1 : npts_reg;
    assign k_eff = (nruns_reg == '0) ? 16'd1 : nruns_reg;

    // Point capture and angle reduction.
    logic signed [RW-1:0] x_ext;
    logic signed [RW-1:0] y_ext;
    logic [RW-1:0]        x_mag;
    logic signed [RW-1:0] y_reg;
    logic                 xneg_reg;
    logic [RW-1:0]        rmag_reg;
    logic [4:0]           red_j;
    logic [RW-1:0]        red_sub;

    assign x_ext   = {{(RW-32){x_point[31]}}, x_point} << YSH;
    assign y_ext   = {{(RW-32){y_point[31]}}, y_point} << YSH;
    assign x_mag   = x_ext[RW-1] ? (RW'(0) - x_ext) : x_ext;
    assign red_j   = 5'(RED_STEPS - 1) - cmd.idx[4:0];
    assign red_sub = TWO_PI_R << red_j;

    // Fold the reduced angle into the range of plus or minus half pi.
    logic [32:0]          rr;
    logic signed [CW-1:0] fa;
    logic signed [CW-1:0] fb;

    always_comb
    begin
        rr = (xneg_reg && (rmag_reg != '0)) ? (mcsi_pkg::TWO_PI_Q30 - rmag_reg[32:0])
                                            : rmag_reg[32:0];
        fa = {{(CW-33){1'b0}}, rr};
        if (fa > PI_S)
        begin
            fa = fa - TWO_PI_S;
        end
        if (fa > HALF_S)
        begin
            fb = PI_S - fa;
        end
        else if (fa < -HALF_S)
        begin
            fb = -PI_S - fa;
        end
        else
        begin
            fb = fa;
        end
    end

    // CORDIC rotation, one step per cycle.
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic signed [CW-1:0] cz_reg;
    logic signed [CW-1:0] cx_sh;
    logic signed [CW-1:0] cy_sh;
    logic signed [CW-1:0] atan_v;

    assign cx_sh  = cx_reg >>> cmd.idx[4:0];
    assign cy_sh  = cy_reg >>> cmd.idx[4:0];
    assign atan_v = mcsi_pkg::atan_q30(cmd.idx[4:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load_point)
        begin
            y_reg    <= y_ext;
            xneg_reg <= x_ext[RW-1];
            rmag_reg <= x_mag;
        end
        else if (cmd.red_step && (rmag_reg >= red_sub))
        begin
            rmag_reg <= rmag_reg - red_sub;
        end
        if (cmd.fold)
        begin
            cx_reg <= GAIN_S;
            cy_reg <= '0;
            cz_reg <= fb;
        end
        else if (cmd.cord_step)
        begin
            if (!cz_reg[CW-1])
            begin
                cx_reg <= cx_reg - cy_sh;
                cy_reg <= cy_reg + cx_sh;
                cz_reg <= cz_reg - atan_v;
            end
            else
            begin
                cx_reg <= cx_reg + cy_sh;
                cy_reg <= cy_reg - cx_sh;
                cz_reg <= cz_reg + atan_v;
            end
        end
    end

    // Hit test and run bookkeeping.
    logic signed [24:0] bal_reg;
    logic [23:0]        pts_reg;
    logic signed [24:0] bal_next;
    logic signed [63:0] ys;
    logic signed [63:0] ss;
    logic               hit_up;
    logic               hit_down;
    logic               run_end;
    logic [24:0]        cnt_mag_reg;
    logic               cnt_neg_reg;

    assign ys       = {{(64-RW){y_reg[RW-1]}}, y_reg};
    assign ss       = {{(64-CW){cy_reg[CW-1]}}, cy_reg};
    assign hit_up   = !ys[63] && (ys <= ss);
    assign hit_down = !hit_up && (ys <= 64'sd0) && (ys >= ss);
    assign run_end  = ({1'b0, pts_reg} + 25'd1) >= {1'b0, n_eff};

    always_comb
    begin
        bal_next = bal_reg;
        if (hit_up && (bal_reg != BAL_MAX))
        begin
            bal_next = bal_reg + 25'sd1;
        end
        else if (hit_down && (bal_reg != BAL_MIN))
        begin
            bal_next = bal_reg - 25'sd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bal_reg <= '0;
            pts_reg <= '0;
        end
        else if (cmd.hit)
        begin
            if (run_end)
            begin
                bal_reg <= '0;
                pts_reg <= '0;
            end
            else
            begin
                bal_reg <= bal_next;
                pts_reg <= pts_reg + 24'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hit)
        begin
            cnt_mag_reg <= bal_next[24] ? (25'd0 - bal_next) : bal_next;
            cnt_neg_reg <= bal_next[24];
        end
    end

    // Area product and its scaling by the balance.
    logic signed [32:0] dw;
    logic signed [32:0] dh;
    logic [32:0]        mw;
    logic [32:0]        mh;
    logic [65:0]        wh_prod;
    logic [57:0]        lo_prod;
    logic [57:0]        hi_prod;
    logic [65:0]        prod_reg;
    logic [90:0]        macc_reg;
    logic               est_neg_reg;

    assign dw      = {high_reg[31], high_reg} - {low_reg[31], low_reg};
    assign dh      = {top_reg[31], top_reg} - {bottom_reg[31], bottom_reg};
    assign mw      = dw[32] ? (33'd0 - dw) : dw;
    assign mh      = dh[32] ? (33'd0 - dh) : dh;
    assign wh_prod = mw * mh;
    assign lo_prod = prod_reg[32:0] * cnt_mag_reg;
    assign hi_prod = prod_reg[65:33] * cnt_mag_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_wh)
        begin
            prod_reg    <= wh_prod;
            est_neg_reg <= (dw[32] != dh[32]) != cnt_neg_reg;
        end
        if (cmd.mul_lo)
        begin
            macc_reg <= 91'(lo_prod);
        end
        else if (cmd.mul_hi)
        begin
            macc_reg <= macc_reg + (91'(hi_prod) << 33);
        end
    end

    // Shared restoring divider, one quotient bit per cycle.
    logic [127:0]       dvd_reg;
    logic [DIVW-1:0]    dvs_reg;
    logic [DIVW-1:0]    rem_reg;
    logic               qneg_reg;
    logic [DIVW:0]      trial;
    logic               q_bit;
    logic [16:0]        runs_div;
    logic [15:0]        runs_reg;
    logic signed [63:0] sum_reg;
    logic signed [63:0] sqsum_reg;

    assign trial    = {rem_reg, dvd_reg[127]};
    assign q_bit    = trial >= {1'b0, dvs_reg};
    assign runs_div = (runs_reg == '0) ? 17'h10000 : {1'b0, runs_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            unique case (cmd.div_src)
                mcsi_pkg::DSRC_EST:
                begin
                    dvd_reg  <= 128'(macc_reg) << SSH;
                    dvs_reg  <= DIVW'(n_eff) << DSH;
                    qneg_reg <= est_neg_reg;
                end
                mcsi_pkg::DSRC_MEAN:
                begin
                    dvd_reg  <= 128'(mag64(sum_reg));
                    dvs_reg  <= DIVW'(runs_div);
                    qneg_reg <= sum_reg[63];
                end
                default:
                begin
                    dvd_reg  <= 128'(mag64(sqsum_reg));
                    dvs_reg  <= DIVW'(runs_div);
                    qneg_reg <= sqsum_reg[63];
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? DIVW'(trial - {1'b0, dvs_reg}) : trial[DIVW-1:0];
            dvd_reg <= {dvd_reg[126:0], q_bit};
        end
    end

    // Signed results taken from the quotient.
    logic signed [63:0] est_reg;
    logic signed [63:0] mean_reg;
    logic signed [63:0] msq_reg;
    logic signed [63:0] est_q;
    logic signed [63:0] small_q;

    always_comb
    begin
        if (qneg_reg)
        begin
            est_q = ((dvd_reg[127:64] != '0) || (dvd_reg[63:0] > 64'h8000_0000_0000_0000))
                    ? SMIN : (64'd0 - dvd_reg[63:0]);
        end
        else
        begin
            est_q = (dvd_reg[127:63] != '0) ? SMAX : dvd_reg[63:0];
        end
    end

    assign small_q = qneg_reg ? (64'd0 - dvd_reg[63:0]) : dvd_reg[63:0];

    always_ff @(posedge clk)
    begin
        if (cmd.take_est)
        begin
            est_reg <= est_q;
        end
        if (cmd.take_mean)
        begin
            mean_reg <= small_q;
        end
        if (cmd.take_msq)
        begin
            msq_reg <= small_q;
        end
    end

    // Q32.32 square from four 32 by 32 partial products.
    logic [63:0]        sq_m;
    logic [31:0]        sq_a;
    logic [31:0]        sq_b;
    logic [63:0]        sq_p;
    logic [127:0]       sq_acc_reg;
    logic signed [63:0] sq_sat;

    assign sq_m   = (cmd.sq_src == mcsi_pkg::SQ_MEAN) ? mag64(mean_reg) : mag64(est_reg);
    assign sq_a   = cmd.idx[1] ? sq_m[63:32] : sq_m[31:0];
    assign sq_b   = cmd.idx[0] ? sq_m[63:32] : sq_m[31:0];
    assign sq_p   = sq_a * sq_b;
    assign sq_sat = (sq_acc_reg[127:95] != '0) ? SMAX : sq_acc_reg[95:32];

    always_ff @(posedge clk)
    begin
        if (cmd.sq_step)
        begin
            unique case (cmd.idx[1:0])
                2'd0:    sq_acc_reg <= 128'(sq_p);
                2'd3:    sq_acc_reg <= sq_acc_reg + (128'(sq_p) << 64);
                default: sq_acc_reg <= sq_acc_reg + (128'(sq_p) << 32);
            endcase
        end
    end

    // Burst statistics.
    logic [15:0] runs_next;
    logic        stats_due_reg;

    assign runs_next = runs_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            runs_reg      <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            stats_due_reg <= 1'b0;
        end
        else if (cmd.acc)
        begin
            runs_reg      <= runs_next;
            sum_reg       <= sat_add(sum_reg, est_reg);
            sqsum_reg     <= sat_add(sqsum_reg, sq_sat);
            stats_due_reg <= !((runs_next != '0) && (runs_next < k_eff));
        end
        else if (cmd.clear_burst)
        begin
            runs_reg  <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
        end
    end

    // Digit-by-digit square root of the difference scaled by 2^32.
    logic signed [63:0] diff_v;
    logic [95:0]        rad_reg;
    logic [47:0]        root_reg;
    logic [49:0]        srem_reg;
    logic [51:0]        s_t;
    logic [51:0]        s_trial;
    logic               s_ge;

    assign diff_v  = msq_reg - sq_sat;
    assign s_t     = {srem_reg, rad_reg[95:94]};
    assign s_trial = {2'b00, root_reg, 2'b01};
    assign s_ge    = s_t >= s_trial;

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            rad_reg  <= {mag64(diff_v), 32'd0};
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg  <= {rad_reg[93:0], 2'b00};
            root_reg <= {root_reg[46:0], s_ge};
            srem_reg <= s_ge ? 50'(s_t - s_trial) : s_t[49:0];
        end
    end

    // Output register.
    logic               out_valid_reg;
    logic [1:0]         kind_reg;
    logic signed [63:0] value_reg;
    logic               final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg  <= cmd.emit_kind;
            final_reg <= cmd.emit_final;
            unique case (cmd.emit_kind)
                mcsi_pkg::KIND_MEAN:  value_reg <= mean_reg;
                mcsi_pkg::KIND_SIGMA: value_reg <= {16'd0, root_reg};
                default:              value_reg <= est_reg;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign result_value  = value_reg;
    assign final_flag    = final_reg;

    assign sts.run_end   = run_end;
    assign sts.stats_due = stats_due_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

endmodule

`default_nettype wire
